// ===== src/pdr_pkg.sv =====
// ----------------------------------------------------------------------------
// pdr_pkg: shared types, constants and functions
// Transfer types, plane record, status codes and the fixed-point helpers
// used by the panorama plane depth raster.
// ----------------------------------------------------------------------------
package pdr_pkg;

  localparam int unsigned MAX_PLANES_DEF       = 256;
  localparam int unsigned MAX_MAP_WIDTH_DEF    = 512;
  localparam int unsigned MAX_MAP_HEIGHT_DEF   = 256;
  localparam int unsigned SINE_TABLE_DEPTH_DEF = 1024;

  localparam int unsigned WIDTH_W  = 10;
  localparam int unsigned HEIGHT_W = 9;
  localparam int unsigned COL_W    = 9;
  localparam int unsigned ROW_W    = 8;
  localparam int unsigned DEPTH_W  = 24;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_PIXEL = 1'b1;

  localparam logic REG_MAP_WIDTH  = 1'b0;
  localparam logic REG_MAP_HEIGHT = 1'b1;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QUEUE_AW    = 2;

  localparam logic [DEPTH_W-1:0] DEPTH_MAX = 24'hFFFFFF;

  // depth byte = floor(depth * 51 / 5120), saturating from this depth up
  localparam logic [DEPTH_W-1:0] BYTE_SAT_DEPTH = 24'd25701;
  localparam int unsigned        BYTE_MUL       = 51;
  localparam int unsigned        BYTE_SHIFT     = 10;
  localparam int unsigned        FIFTH_MUL      = 3277;
  localparam int unsigned        FIFTH_SHIFT    = 14;

  localparam logic [63:0] PI_Q30      = 64'd3373259426;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] TWO_PI_Q30  = 64'd6746518852;

  typedef enum logic [1:0] {
    ST_NONE = 2'd0,
    ST_HIT  = 2'd1,
    ST_SAT  = 2'd2
  } status_t;

  typedef struct packed {
    logic                cmd;
    logic [7:0]          plane_slot;
    logic signed [15:0]  normal_x;
    logic signed [15:0]  normal_y;
    logic signed [15:0]  normal_z;
    logic signed [23:0]  plane_distance;
    logic [7:0]          pixel_plane;
    logic [COL_W-1:0]    column;
    logic [ROW_W-1:0]    row;
  } in_item_t;

  typedef struct packed {
    logic [DEPTH_W-1:0]  depth_fixed;
    logic [7:0]          depth_byte;
    logic [1:0]          depth_status;
    logic [COL_W-1:0]    out_column;
    logic [ROW_W-1:0]    out_row;
  } out_item_t;

  typedef struct packed {
    logic signed [15:0]  normal_x;
    logic signed [15:0]  normal_y;
    logic signed [15:0]  normal_z;
    logic signed [23:0]  plane_distance;
  } plane_t;

  typedef struct packed {
    logic                has_plane;
    logic [COL_W-1:0]    out_col;
    logic [ROW_W-1:0]    out_row;
  } pix_side_t;

  typedef struct packed {
    logic                load_en;
    logic                pixel;
    logic                has_plane;
    logic [7:0]          idx;
    plane_t              plane;
    logic [WIDTH_W-1:0]  xm;
    logic [WIDTH_W-1:0]  wm1;
    logic [HEIGHT_W-1:0] ym;
    logic [HEIGHT_W-1:0] hm1;
    logic [COL_W-1:0]    out_col;
    logic [ROW_W-1:0]    out_row;
  } q_item_t;

  // q1.14 sine of 2*pi*k/2^db from a q30 taylor series, rounded to nearest
  function automatic logic signed [15:0] sine_entry(input int unsigned db,
                                                    input int unsigned k);
    logic [63:0] a;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] r;
    logic        neg;
    a   = (64'(k) * TWO_PI_Q30 + (64'd1 << (db - 1))) >> db;
    neg = 1'b0;
    if (a >= PI_Q30) begin
      a   = a - PI_Q30;
      neg = 1'b1;
    end
    if (a > HALF_PI_Q30) begin
      a = PI_Q30 - a;
    end
    x2   = (a * a) >> 30;
    term = a;
    sum  = a;
    term = ((term * x2) >> 30) / 6;
    sum  = sum - term;
    term = ((term * x2) >> 30) / 20;
    sum  = sum + term;
    term = ((term * x2) >> 30) / 42;
    sum  = sum - term;
    term = ((term * x2) >> 30) / 72;
    sum  = sum + term;
    term = ((term * x2) >> 30) / 110;
    sum  = sum - term;
    term = ((term * x2) >> 30) / 156;
    sum  = sum + term;
    r    = (sum + 64'd32768) >> 16;
    return neg ? -16'(r) : 16'(r);
  endfunction

  // q1.14 product, rounded to nearest with a half away from zero
  function automatic logic signed [15:0] mul_q14(input logic signed [15:0] a,
                                                 input logic signed [15:0] b);
    logic signed [31:0] p;
    logic [31:0]        mag;
    logic [31:0]        r;
    p   = a * b;
    mag = p[31] ? 32'(-p) : 32'(p);
    r   = (mag + 32'd8192) >> 14;
    return p[31] ? -16'(r) : 16'(r);
  endfunction

endpackage

// ===== src/pdr_front.sv =====
// ----------------------------------------------------------------------------
// pdr_front: item classification
// Sorts each accepted item into load or pixel, clamps the pixel position to
// the map and forms the mirrored column and flipped row for the back end.
// ----------------------------------------------------------------------------
module pdr_front
  import pdr_pkg::*;
#(
  parameter int unsigned MAX_PLANES     = MAX_PLANES_DEF,
  parameter int unsigned MAX_MAP_WIDTH  = MAX_MAP_WIDTH_DEF,
  parameter int unsigned MAX_MAP_HEIGHT = MAX_MAP_HEIGHT_DEF
) (
  input  in_item_t            item,
  input  logic [WIDTH_W-1:0]  map_width,
  input  logic [HEIGHT_W-1:0] map_height,
  output q_item_t             q_item
);

  localparam int unsigned WCAP = (MAX_MAP_WIDTH > 1023) ? 1023 : MAX_MAP_WIDTH;
  localparam int unsigned HCAP = (MAX_MAP_HEIGHT > 511) ? 511 : MAX_MAP_HEIGHT;

  logic [WIDTH_W-1:0]  w_eff;
  logic [WIDTH_W-1:0]  wm1;
  logic [WIDTH_W-1:0]  col_c;
  logic [HEIGHT_W-1:0] h_eff;
  logic [HEIGHT_W-1:0] hm1;
  logic [HEIGHT_W-1:0] row_c;
  logic                slot_ok;
  logic                plane_ok;
  logic                is_pixel;

  always_comb begin
    if (map_width < WIDTH_W'(2)) begin
      w_eff = WIDTH_W'(2);
    end else if (map_width > WIDTH_W'(WCAP)) begin
      w_eff = WIDTH_W'(WCAP);
    end else begin
      w_eff = map_width;
    end
    if (map_height < HEIGHT_W'(2)) begin
      h_eff = HEIGHT_W'(2);
    end else if (map_height > HEIGHT_W'(HCAP)) begin
      h_eff = HEIGHT_W'(HCAP);
    end else begin
      h_eff = map_height;
    end
  end

  assign wm1   = w_eff - WIDTH_W'(1);
  assign hm1   = h_eff - HEIGHT_W'(1);
  assign col_c = ({1'b0, item.column} > wm1) ? wm1 : {1'b0, item.column};
  assign row_c = ({1'b0, item.row} > hm1) ? hm1 : {1'b0, item.row};

  assign is_pixel = (item.cmd == CMD_PIXEL);
  assign slot_ok  = ({1'b0, item.plane_slot} < 9'(MAX_PLANES));
  assign plane_ok = (item.pixel_plane != 8'd0) && ({1'b0, item.pixel_plane} < 9'(MAX_PLANES));

  always_comb begin
    q_item.load_en   = !is_pixel && slot_ok;
    q_item.pixel     = is_pixel;
    q_item.has_plane = plane_ok;
    q_item.idx       = is_pixel ? item.pixel_plane : item.plane_slot;
    q_item.plane.normal_x       = item.normal_x;
    q_item.plane.normal_y       = item.normal_y;
    q_item.plane.normal_z       = item.normal_z;
    q_item.plane.plane_distance = item.plane_distance;
    q_item.xm      = wm1 - col_c;
    q_item.wm1     = wm1;
    q_item.ym      = hm1 - row_c;
    q_item.hm1     = hm1;
    q_item.out_col = q_item.xm[COL_W-1:0];
    q_item.out_row = row_c[ROW_W-1:0];
  end

endmodule

// ===== src/pdr_queue.sv =====
// ----------------------------------------------------------------------------
// pdr_queue: front to back item queue
// Small queue that lets the front keep taking items while the back is held.
// ----------------------------------------------------------------------------
module pdr_queue
  import pdr_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  q_item_t push_item,
  input  logic    pop,
  output logic    full,
  output logic    q_vld,
  output q_item_t q_item
);

  q_item_t             slot_r [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr_r;
  logic [QUEUE_AW-1:0] rd_ptr_r;
  logic [QUEUE_AW:0]   cnt_r;
  logic [QUEUE_AW:0]   cnt_nxt;

  assign full   = (cnt_r == (QUEUE_AW + 1)'(QUEUE_DEPTH));
  assign q_vld  = (cnt_r != '0);
  assign q_item = slot_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

// ===== src/pdr_div.sv =====
// ----------------------------------------------------------------------------
// pdr_div: pipelined restoring divider
// One quotient bit per stage; flags a quotient that does not fit in QW bits
// (a zero divisor included).
// ----------------------------------------------------------------------------
module pdr_div
  import pdr_pkg::*;
#(
  parameter int unsigned NW = 52,
  parameter int unsigned VW = 32,
  parameter int unsigned QW = 24,
  parameter int unsigned SW = 18
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_vld,
  input  logic [NW-1:0] in_num,
  input  logic [VW-1:0] in_den,
  input  logic [SW-1:0] in_side,
  output logic          out_vld,
  output logic [QW-1:0] out_quo,
  output logic          out_ovf,
  output logic [SW-1:0] out_side
);

  localparam int unsigned CW = (NW - QW > VW) ? NW - QW : VW;

  logic [CW-1:0] top_c;
  logic [CW-1:0] den_c;

  logic          vld_r  [QW+1];
  logic [VW-1:0] rem_r  [QW+1];
  logic [QW-1:0] low_r  [QW+1];
  logic [QW-1:0] quo_r  [QW+1];
  logic [VW-1:0] den_r  [QW+1];
  logic          ovf_r  [QW+1];
  logic [SW-1:0] side_r [QW+1];

  assign top_c = CW'(in_num[NW-1:QW]);
  assign den_c = CW'(in_den);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0]  <= top_c[VW-1:0];
      low_r[0]  <= in_num[QW-1:0];
      quo_r[0]  <= '0;
      den_r[0]  <= in_den;
      ovf_r[0]  <= (top_c >= den_c);
      side_r[0] <= in_side;
    end
  end

  for (genvar k = 1; k <= QW; k++) begin : g_stage
    logic [VW:0] trial;
    logic        ge;

    assign trial = {rem_r[k-1], low_r[k-1][QW-k]};
    assign ge    = (trial >= {1'b0, den_r[k-1]});

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= vld_r[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= ge ? VW'(trial - {1'b0, den_r[k-1]}) : trial[VW-1:0];
        low_r[k]  <= low_r[k-1];
        quo_r[k]  <= {quo_r[k-1][QW-2:0], ge};
        den_r[k]  <= den_r[k-1];
        ovf_r[k]  <= ovf_r[k-1];
        side_r[k] <= side_r[k-1];
      end
    end
  end

  assign out_vld  = vld_r[QW];
  assign out_quo  = quo_r[QW];
  assign out_ovf  = ovf_r[QW];
  assign out_side = side_r[QW];

endmodule

// ===== src/pdr_back.sv =====
// ----------------------------------------------------------------------------
// pdr_back: plane lookup and depth pipeline
// Plane table, angle dividers, sine lookups, view direction, dot product,
// depth divider, depth byte and the output register.
// ----------------------------------------------------------------------------
module pdr_back
  import pdr_pkg::*;
#(
  parameter int unsigned MAX_PLANES       = MAX_PLANES_DEF,
  parameter int unsigned SINE_TABLE_DEPTH = SINE_TABLE_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_vld,
  input  q_item_t   q_item,
  output logic      q_pop,
  output logic      out_vld,
  input  logic      out_stall,
  output out_item_t out_item
);

  localparam int unsigned DB  = $clog2(SINE_TABLE_DEPTH);
  localparam int unsigned PW  = $clog2(MAX_PLANES);
  localparam int unsigned AQW = DB + 1;
  localparam int unsigned NXW = DB + 12;
  localparam int unsigned NYW = DB + 10;
  localparam int unsigned XVW = WIDTH_W + 1;
  localparam int unsigned YVW = HEIGHT_W + 1;
  localparam int unsigned SSW = $bits(pix_side_t);
  localparam int unsigned PLW = $bits(plane_t);
  localparam int unsigned DNW = DEPTH_W + 28;
  localparam int unsigned DVW = 32;

  logic en;

  // plane table and lookup stage
  plane_t  plane_mem [MAX_PLANES];
  plane_t  rd_r;
  q_item_t m_item_r;
  logic    m_vld_r;

  assign en    = !(out_vld && out_stall);
  assign q_pop = en && q_vld;

  always_ff @(posedge clk) begin
    if (en) begin
      if (q_pop && q_item.load_en) begin
        plane_mem[q_item.idx[PW-1:0]] <= q_item.plane;
      end
      rd_r     <= plane_mem[q_item.idx[PW-1:0]];
      m_item_r <= q_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_vld_r <= 1'b0;
    end else if (en) begin
      m_vld_r <= q_pop && q_item.pixel;
    end
  end

  // angle dividers: theta and phi table positions
  pix_side_t          m_side;
  logic [NXW-1:0]     x_num;
  logic [NYW-1:0]     y_num;
  logic               ax_vld;
  logic [AQW-1:0]     ax_quo;
  logic [SSW-1:0]     ax_side;
  logic [AQW-1:0]     ay_quo;
  logic [PLW-1:0]     ay_side;

  assign m_side.has_plane = m_item_r.has_plane;
  assign m_side.out_col   = m_item_r.out_col;
  assign m_side.out_row   = m_item_r.out_row;
  assign x_num = NXW'({m_item_r.xm, {(DB + 1){1'b0}}}) + NXW'(m_item_r.wm1);
  assign y_num = NYW'({m_item_r.ym, {DB{1'b0}}}) + NYW'(m_item_r.hm1);

  pdr_div #(.NW(NXW), .VW(XVW), .QW(AQW), .SW(SSW)) u_div_x (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (m_vld_r),
    .in_num   (x_num),
    .in_den   ({m_item_r.wm1, 1'b0}),
    .in_side  (m_side),
    .out_vld  (ax_vld),
    .out_quo  (ax_quo),
    .out_ovf  (),
    .out_side (ax_side)
  );

  pdr_div #(.NW(NYW), .VW(YVW), .QW(AQW), .SW(PLW)) u_div_y (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (m_vld_r),
    .in_num   (y_num),
    .in_den   ({m_item_r.hm1, 1'b0}),
    .in_side  (rd_r),
    .out_vld  (),
    .out_quo  (ay_quo),
    .out_ovf  (),
    .out_side (ay_side)
  );

  // sine lookups, two copies with two read ports each
  logic signed [15:0] sine_rom_a [SINE_TABLE_DEPTH];
  logic signed [15:0] sine_rom_b [SINE_TABLE_DEPTH];

  for (genvar k = 0; k < SINE_TABLE_DEPTH; k++) begin : g_rom
    localparam logic signed [15:0] SVAL = sine_entry(DB, k);
    assign sine_rom_a[k] = SVAL;
    assign sine_rom_b[k] = SVAL;
  end

  logic [DB-1:0]      st_idx;
  logic [DB-1:0]      ct_idx;
  logic [DB-1:0]      sp_idx;
  logic [DB-1:0]      cp_idx;
  logic signed [15:0] st_r;
  logic signed [15:0] ct_r;
  logic signed [15:0] sp_r;
  logic signed [15:0] cp_r;
  pix_side_t          s_side_r;
  plane_t             s_pl_r;
  logic               s_vld_r;

  assign st_idx = ax_quo[DB-1:0] + DB'(SINE_TABLE_DEPTH / 4);
  assign ct_idx = ax_quo[DB-1:0] + DB'(SINE_TABLE_DEPTH / 2);
  assign sp_idx = ay_quo[DB-1:0];
  assign cp_idx = ay_quo[DB-1:0] + DB'(SINE_TABLE_DEPTH / 4);

  always_ff @(posedge clk) begin
    if (en) begin
      st_r     <= sine_rom_a[st_idx];
      ct_r     <= sine_rom_a[ct_idx];
      sp_r     <= sine_rom_b[sp_idx];
      cp_r     <= sine_rom_b[cp_idx];
      s_side_r <= pix_side_t'(ax_side);
      s_pl_r   <= plane_t'(ay_side);
    end
  end

  // view direction
  logic signed [15:0] vx_r;
  logic signed [15:0] vy_r;
  logic signed [15:0] vz_r;
  pix_side_t          p_side_r;
  plane_t             p_pl_r;
  logic               p_vld_r;

  always_ff @(posedge clk) begin
    if (en) begin
      vx_r     <= mul_q14(sp_r, ct_r);
      vy_r     <= mul_q14(sp_r, st_r);
      vz_r     <= cp_r;
      p_side_r <= s_side_r;
      p_pl_r   <= s_pl_r;
    end
  end

  // dot product, products then sum
  logic signed [31:0] prod_x_r;
  logic signed [31:0] prod_y_r;
  logic signed [31:0] prod_z_r;
  logic signed [23:0] d1_dist_r;
  pix_side_t          d1_side_r;
  logic               d1_vld_r;
  logic signed [32:0] dot_r;
  logic signed [23:0] d2_dist_r;
  pix_side_t          d2_side_r;
  logic               d2_vld_r;

  always_ff @(posedge clk) begin
    if (en) begin
      prod_x_r  <= vx_r * p_pl_r.normal_x;
      prod_y_r  <= vy_r * p_pl_r.normal_y;
      prod_z_r  <= vz_r * p_pl_r.normal_z;
      d1_dist_r <= p_pl_r.plane_distance;
      d1_side_r <= p_side_r;
      dot_r     <= {prod_x_r[31], prod_x_r} + {prod_y_r[31], prod_y_r}
                 + {prod_z_r[31], prod_z_r};
      d2_dist_r <= d1_dist_r;
      d2_side_r <= d1_side_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_vld_r  <= 1'b0;
      p_vld_r  <= 1'b0;
      d1_vld_r <= 1'b0;
      d2_vld_r <= 1'b0;
    end else if (en) begin
      s_vld_r  <= ax_vld;
      p_vld_r  <= s_vld_r;
      d1_vld_r <= p_vld_r;
      d2_vld_r <= d1_vld_r;
    end
  end

  // depth = round(|d| * 2^28 / |dot|)
  logic [32:0]        adot;
  logic [DEPTH_W-1:0] adist;
  logic [DNW-1:0]     d_num;
  logic               dv_vld;
  logic [DEPTH_W-1:0] dv_quo;
  logic               dv_ovf;
  logic [SSW-1:0]     dv_side;

  assign adot  = dot_r[32] ? 33'(-dot_r) : 33'(dot_r);
  assign adist = d2_dist_r[23] ? DEPTH_W'(-d2_dist_r) : DEPTH_W'(d2_dist_r);
  assign d_num = {adist, 28'd0} + DNW'(adot[32:1]);

  pdr_div #(.NW(DNW), .VW(DVW), .QW(DEPTH_W), .SW(SSW)) u_div_depth (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (d2_vld_r),
    .in_num   (d_num),
    .in_den   (adot[DVW-1:0]),
    .in_side  (d2_side_r),
    .out_vld  (dv_vld),
    .out_quo  (dv_quo),
    .out_ovf  (dv_ovf),
    .out_side (dv_side)
  );

  // status, saturation and first half of the depth byte
  pix_side_t          dv_s;
  logic [DEPTH_W-1:0] depth_sel;
  logic [1:0]         status_sel;
  logic [29:0]        byte_prod;
  logic [DEPTH_W-1:0] f_depth_r;
  logic [1:0]         f_status_r;
  logic               f_sat_r;
  logic [10:0]        f_y_r;
  pix_side_t          f_side_r;
  logic               f_vld_r;

  assign dv_s = pix_side_t'(dv_side);

  always_comb begin
    if (!dv_s.has_plane) begin
      depth_sel  = '0;
      status_sel = ST_NONE;
    end else if (dv_ovf) begin
      depth_sel  = DEPTH_MAX;
      status_sel = ST_SAT;
    end else begin
      depth_sel  = dv_quo;
      status_sel = ST_HIT;
    end
  end

  assign byte_prod = 30'(depth_sel) * 30'(BYTE_MUL);

  always_ff @(posedge clk) begin
    if (en) begin
      f_depth_r  <= depth_sel;
      f_status_r <= status_sel;
      f_sat_r    <= (depth_sel >= BYTE_SAT_DEPTH);
      f_y_r      <= byte_prod[BYTE_SHIFT+10:BYTE_SHIFT];
      f_side_r   <= dv_s;
    end
  end

  // output register
  logic [22:0] fifth_prod;
  out_item_t   out_r;
  logic        out_vld_r;

  assign fifth_prod = 23'(f_y_r) * 23'(FIFTH_MUL);

  always_ff @(posedge clk) begin
    if (en) begin
      out_r.depth_fixed  <= f_depth_r;
      out_r.depth_byte   <= f_sat_r ? 8'hFF : fifth_prod[FIFTH_SHIFT+7:FIFTH_SHIFT];
      out_r.depth_status <= f_status_r;
      out_r.out_column   <= f_side_r.out_col;
      out_r.out_row      <= f_side_r.out_row;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_vld_r   <= 1'b0;
      out_vld_r <= 1'b0;
    end else if (en) begin
      f_vld_r   <= dv_vld;
      out_vld_r <= f_vld_r;
    end
  end

  assign out_vld  = out_vld_r;
  assign out_item = out_r;

endmodule

// ===== src/panorama_plane_depth_raster_core.sv =====
// ----------------------------------------------------------------------------
// panorama_plane_depth_raster_core: equirectangular depth map from planes
// Loads plane entries into a table and turns pixel items into depth values,
// depth bytes and mirrored columns, one pixel per clock unless out_stall holds a result.
// ----------------------------------------------------------------------------
//
//   channel   signals                              transfer when
//   -------   ----------------------------------   ------------------------
//   input     in_valid, in_stall, in_data          in_valid && !in_stall
//   result    out_valid, out_stall, out_data       out_valid && !out_stall
//   config    psel, penable, pwrite, paddr, ...    psel && penable && pwrite
//
// one item per clock sustained unless out_stall holds a result; a pixel
// passes the queue, the plane lookup, the pipelined angle and depth
// dividers and the registers between them before its out_valid rises
// load items write the plane table and give no result
// synchronous active-low reset clears control state only; the plane table
// is not cleared, and a pixel naming an unloaded plane gives an undefined depth
// out_stall with out_valid high freezes the back pipeline; a four-entry
// queue keeps taking input transfers until it fills, then in_stall rises
//
module panorama_plane_depth_raster_core
  import pdr_pkg::*;
#(
  parameter int unsigned MAX_PLANES       = MAX_PLANES_DEF,
  parameter int unsigned MAX_MAP_WIDTH    = MAX_MAP_WIDTH_DEF,
  parameter int unsigned MAX_MAP_HEIGHT   = MAX_MAP_HEIGHT_DEF,
  parameter int unsigned SINE_TABLE_DEPTH = SINE_TABLE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // configuration registers: map width at 0x0, map height at 0x4
  logic [WIDTH_W-1:0]  map_width_r;
  logic [HEIGHT_W-1:0] map_height_r;
  logic                cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_width_r  <= WIDTH_W'(512);
      map_height_r <= HEIGHT_W'(256);
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_MAP_WIDTH:  map_width_r  <= pwdata[WIDTH_W-1:0];
        REG_MAP_HEIGHT: map_height_r <= pwdata[HEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_MAP_WIDTH:  prdata = 32'(map_width_r);
      REG_MAP_HEIGHT: prdata = 32'(map_height_r);
      default:        prdata = '0;
    endcase
  end

  // front: clamp, mirror and classify each input transfer
  q_item_t f_item;
  logic    push;
  logic    q_full;
  logic    q_vld;
  logic    q_pop;
  q_item_t q_item;

  assign in_stall = q_full;
  assign push     = in_valid && !q_full;

  pdr_front #(
    .MAX_PLANES     (MAX_PLANES),
    .MAX_MAP_WIDTH  (MAX_MAP_WIDTH),
    .MAX_MAP_HEIGHT (MAX_MAP_HEIGHT)
  ) u_front (
    .item       (in_data),
    .map_width  (map_width_r),
    .map_height (map_height_r),
    .q_item     (f_item)
  );

  // queue between front and back
  pdr_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (f_item),
    .pop       (q_pop),
    .full      (q_full),
    .q_vld     (q_vld),
    .q_item    (q_item)
  );

  // back: plane table, angles, dot product, depth divide, output register
  pdr_back #(
    .MAX_PLANES       (MAX_PLANES),
    .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_vld     (q_vld),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .out_vld   (out_valid),
    .out_stall (out_stall),
    .out_item  (out_data)
  );

  // a pixel with no plane carries a zero depth and a zero byte
  a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.depth_status == ST_NONE) |->
      (out_data.depth_fixed == '0) && (out_data.depth_byte == 8'd0))
    else $error("no-plane result with nonzero depth");

  // a saturated result is full scale in both depth forms
  a_sat_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.depth_status == ST_SAT) |->
      (out_data.depth_fixed == DEPTH_MAX) && (out_data.depth_byte == 8'hFF))
    else $error("saturated result not at full scale");

  // an input transfer always leaves the queue non-empty next cycle
  a_push_seen: assert property (@(posedge clk) disable iff (!rst_n)
    push |=> q_vld)
    else $error("queue empty after an input transfer");

endmodule
